@@ hw/rtl/lcp_pkg.sv @@
// Shared types and constants of the leveled compaction planner.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lcp_pkg;

  localparam int TIME_W      = 64;
  localparam int RANGE_W     = 63;
  localparam int CNT32_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int RANGE_REGS  = 6;
  localparam int MAX_RESULTS = 16;
  localparam int PICK_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LAST  = 3'd6;

  localparam logic [2:0] RANGE_COUNT_RESET = 3'd3;
  localparam logic [RANGE_W-1:0] RANGE_RESET [RANGE_REGS] = '{
    63'd7200000, 63'd21600000, 63'd64800000,
    63'd194400000, 63'd583200000, 63'd1749600000
  };

  typedef enum logic [1:0] {
    RSN_NONE     = 2'd0,
    RSN_OVERLAP  = 2'd1,
    RSN_LEVELED  = 2'd2,
    RSN_TOMB     = 2'd3
  } lcp_reason_t;

  typedef struct packed {
    logic [TIME_W-1:0]  span_start;
    logic [TIME_W-1:0]  span_end;
    logic               failed_before;
    logic [CNT32_W-1:0] tombstone_count;
    logic [CNT32_W-1:0] series_count;
  } lcp_rec_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RK_RDI, S_RK_LDI, S_RK_RDJ, S_RK_CMP, S_RK_WR,
    S_OV_RD0, S_OV_LD0, S_OV_RD, S_OV_EV,
    S_LV_INIT, S_LV_RDH, S_LV_LDH, S_LV_RANGE, S_LV_RD, S_LV_LD, S_LV_DIV,
    S_LV_FIRST, S_LV_GRD, S_LV_GEV, S_LV_CHK,
    S_TB_INIT, S_TB_RD, S_TB_EV, S_EM_INIT, S_EM_RD, S_EM_OUT, S_NONE_OUT
  } lcp_state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_RK_RDI, OP_RK_LDI, OP_RK_RDJ, OP_RK_CMP, OP_RK_WR,
    OP_OV_RD0, OP_OV_LD0, OP_OV_RD, OP_OV_EV,
    OP_LV_RDH, OP_LV_LDH, OP_LV_RANGE, OP_LV_RD, OP_LV_LD, OP_LV_DIV,
    OP_LV_FIRST, OP_LV_GRD, OP_LV_GEV, OP_LV_CHK,
    OP_TB_INIT, OP_TB_RD, OP_TB_EV, OP_EM_INIT, OP_EM_RD, OP_EM_OUT, OP_NONE_OUT
  } lcp_op_t;

  typedef struct packed {
    lcp_op_t op;
  } lcp_cmd_t;

  typedef struct packed {
    logic j_end;
    logic i_last;
    logic n_ge2;
    logic ov_hit;
    logic ov_found;
    logic lv_run;
    logic lv_last;
    logic div_done;
    logic exc;
    logic grp_ok;
    logic k_zero;
    logic tb_hit;
    logic em_last;
  } lcp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/lcp_rem_div.sv @@
// Bit-serial restoring remainder unit: 64-bit unsigned dividend, 63-bit divisor.
// One quotient bit per cycle; depends on lcp_pkg.
`default_nettype none

module lcp_rem_div import lcp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TIME_W-1:0]  dividend,
  input  logic [RANGE_W-1:0] divisor,
  output logic               done,
  output logic [RANGE_W-1:0] rem
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [TIME_W-1:0]  q_r, q_nxt;
  logic [RANGE_W-1:0] rem_r, rem_nxt;
  logic [RANGE_W-1:0] d_r, d_nxt;
  logic [TIME_W-1:0]  trial;
  logic [TIME_W-1:0]  diff;

  assign trial = {rem_r, q_r[TIME_W-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[TIME_W-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, d_r}) ? diff[RANGE_W-1:0] : trial[RANGE_W-1:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  // The remainder handed out is always reduced below the divisor in use.
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < d_r) else $error("remainder not reduced");

endmodule

`default_nettype wire

@@ hw/rtl/lcp_dpath.sv @@
// Datapath of the planner: descriptor and sorted memories, configuration
// registers, walk counters, comparators and result register. Uses lcp_pkg, lcp_rem_div.
`default_nettype none

module lcp_dpath import lcp_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int MAX_LEVELS = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lcp_cmd_t                cmd,
  output lcp_sts_t                sts,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [RANGE_W-1:0]      cfg_data,
  input  logic signed [TIME_W-1:0] in_span_start,
  input  logic signed [TIME_W-1:0] in_span_end,
  input  logic                    in_failed_before,
  input  logic [CNT32_W-1:0]      in_tombstone_count,
  input  logic [CNT32_W-1:0]      in_series_count,
  output logic                    out_strobe,
  output logic [PICK_W-1:0]       out_picked_index,
  output logic [1:0]              out_pick_reason,
  output logic                    out_run_end
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [2:0] LV_MAX = 3'(MAX_LEVELS);
  localparam logic [PICK_W-1:0] EMIT_LAST = PICK_W'(MAX_RESULTS - 1);

  lcp_rec_t          rec_mem  [MAX_BLOCKS];
  lcp_rec_t          srt_mem  [MAX_BLOCKS];
  logic [IDX_W-1:0]  sidx_mem [MAX_BLOCKS];

  lcp_rec_t          rec_q, srt_q, rec_in;
  logic [IDX_W-1:0]  sidx_q;
  logic [IDX_W-1:0]  rec_raddr, s_raddr;

  logic [2:0]         range_count_r;
  logic [RANGE_W-1:0] range_r [RANGE_REGS];

  logic [CNT_W-1:0]  cnt_r, i_r, j_r;
  logic [IDX_W-1:0]  rank_r, first_r, last_r, p_r;
  logic [PICK_W-1:0] ecnt_r;
  logic [2:0]        lv_r;
  logic [TIME_W-1:0] key_i_r, maxk_r, highk_r, mt_r, gap_r, le_r, mid_r;
  lcp_rec_t          ent_r, cur_r;
  logic              found_r, bad_r, neg_r;
  logic [RANGE_W-1:0] r_r;
  lcp_reason_t       reason_r;

  logic              out_strobe_r;
  logic [PICK_W-1:0] out_idx_r;
  lcp_reason_t       out_reason_r;
  logic              out_end_r;

  logic [2:0]         rc_eff, mid_lv;
  logic [RANGE_W-1:0] rng_lv, rng_mid, rng_lv_eff, rng_mid_eff;
  logic [CNT_W-1:0]   cnt_m1, cnt_m2, i_m1, grp_size;
  logic [TIME_W-1:0]  exc_hi, exc_lo, exc_gap, exc_diff, le_diff, div_a;
  logic               rk_less;
  logic [36:0]        tomb20;
  logic               div_done;
  logic [RANGE_W-1:0] div_rem;
  logic [IDX_W+PICK_W-1:0] sidx_ext;
  lcp_op_t            op;

  assign op = cmd.op;

  assign rec_in.span_start      = in_span_start;
  assign rec_in.span_end        = in_span_end;
  assign rec_in.failed_before   = in_failed_before;
  assign rec_in.tombstone_count = in_tombstone_count;
  assign rec_in.series_count    = in_series_count;

  // A range count of zero acts as one level, values above the limit as the limit.
  always_comb begin
    rc_eff = range_count_r;
    if (range_count_r == 3'd0) rc_eff = 3'd1;
    if (range_count_r > LV_MAX) rc_eff = LV_MAX;
    mid_lv  = rc_eff >> 1;
    rng_lv  = range_r[0];
    rng_mid = range_r[0];
    for (int k = 0; k < RANGE_REGS; k++) begin
      if (3'(k) == lv_r) rng_lv = range_r[k];
      if (3'(k) == mid_lv) rng_mid = range_r[k];
    end
    rng_lv_eff  = (rng_lv == '0) ? RANGE_W'(1) : rng_lv;
    rng_mid_eff = (rng_mid == '0) ? RANGE_W'(1) : rng_mid;
  end

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_m2   = cnt_r - CNT_W'(2);
  assign i_m1     = i_r - CNT_W'(1);
  assign grp_size = i_r - CNT_W'(first_r);

  assign rec_raddr = (op == OP_RK_RDI) ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];

  always_comb begin
    case (op)
      OP_OV_RD, OP_LV_RD, OP_LV_GRD: s_raddr = i_r[IDX_W-1:0];
      OP_LV_RDH:                     s_raddr = cnt_m2[IDX_W-1:0];
      OP_TB_RD:                      s_raddr = i_m1[IDX_W-1:0];
      OP_EM_RD:                      s_raddr = p_r;
      default:                       s_raddr = '0;
    endcase
  end

  // Shared window test: hi - lo exceeds gap, exactly and without wrap.
  always_comb begin
    case (op)
      OP_LV_FIRST: begin
        exc_hi  = cur_r.span_end;
        exc_lo  = mt_r;
        exc_gap = gap_r;
      end
      OP_TB_EV: begin
        exc_hi  = srt_q.span_end;
        exc_lo  = srt_q.span_start;
        exc_gap = mid_r;
      end
      default: begin
        exc_hi  = srt_q.span_end;
        exc_lo  = mt_r;
        exc_gap = gap_r;
      end
    endcase
    exc_diff = exc_hi - exc_lo;
  end

  assign rk_less = ($signed(rec_q.span_start) < $signed(key_i_r)) ||
                   ((rec_q.span_start == key_i_r) && (j_r < i_r));
  assign tomb20  = {1'b0, srt_q.tombstone_count, 4'b0} + {3'b0, srt_q.tombstone_count, 2'b0};
  assign le_diff = le_r - mt_r;
  assign div_a   = srt_q.span_start[TIME_W-1] ? (TIME_W'(0) - srt_q.span_start)
                                              : srt_q.span_start;

  lcp_rem_div u_rem_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == OP_LV_LD),
    .dividend (div_a),
    .divisor  (r_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    sts.j_end    = (j_r == cnt_m1);
    sts.i_last   = (i_r == cnt_m1);
    sts.n_ge2    = (cnt_r > CNT_W'(1));
    sts.ov_hit   = $signed(srt_q.span_start) < $signed(maxk_r);
    sts.ov_found = found_r;
    sts.lv_run   = (rc_eff >= 3'd2) && (cnt_r > CNT_W'(1));
    sts.lv_last  = ((lv_r + 3'd1) == rc_eff);
    sts.div_done = div_done;
    sts.exc      = ($signed(exc_hi) > $signed(exc_lo)) && (exc_diff > exc_gap);
    sts.grp_ok   = !bad_r && (grp_size > CNT_W'(1)) &&
                   ((($signed(le_r) > $signed(mt_r)) && (le_diff == {1'b0, r_r})) ||
                    ($signed(le_r) <= $signed(highk_r)));
    sts.k_zero   = (i_r == '0);
    sts.tb_hit   = tomb20 > {5'b0, srt_q.series_count};
    sts.em_last  = (p_r == last_r) || (ecnt_r == EMIT_LAST);
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    rec_q  <= rec_mem[rec_raddr];
    srt_q  <= srt_mem[s_raddr];
    sidx_q <= sidx_mem[s_raddr];
    if (op == OP_LOAD && cnt_r < CNT_MAX) rec_mem[cnt_r[IDX_W-1:0]] <= rec_in;
    if (op == OP_RK_WR) begin
      srt_mem[rank_r]  <= ent_r;
      sidx_mem[rank_r] <= i_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_count_r <= RANGE_COUNT_RESET;
      for (int k = 0; k < RANGE_REGS; k++) range_r[k] <= RANGE_RESET[k];
    end else if (cfg_we) begin
      if (cfg_index == REG_RANGE_COUNT) begin
        range_count_r <= cfg_data[2:0];
      end else if (cfg_index <= REG_RANGE_LAST) begin
        for (int k = 0; k < RANGE_REGS; k++) begin
          if (cfg_index - REG_RANGE_FIRST == 3'(k)) range_r[k] <= cfg_data;
        end
      end
    end
  end

  assign sidx_ext = {{PICK_W{1'b0}}, sidx_q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (op)
        OP_LOAD: begin
          if (cnt_r < CNT_MAX) cnt_r <= cnt_r + CNT_W'(1);
        end
        OP_EM_OUT: begin
          out_strobe_r <= 1'b1;
          if (sts.em_last) cnt_r <= '0;
        end
        OP_NONE_OUT: begin
          out_strobe_r <= 1'b1;
          cnt_r        <= '0;
        end
        default: ;
      endcase
    end

    case (op)
      OP_LOAD: i_r <= '0;
      OP_RK_LDI: begin
        key_i_r <= rec_q.span_start;
        ent_r   <= rec_q;
        j_r     <= '0;
        rank_r  <= '0;
      end
      OP_RK_CMP: begin
        if (rk_less) rank_r <= rank_r + IDX_W'(1);
        j_r <= j_r + CNT_W'(1);
      end
      OP_RK_WR: i_r <= i_r + CNT_W'(1);
      OP_OV_LD0: begin
        maxk_r  <= srt_q.span_end;
        i_r     <= CNT_W'(1);
        found_r <= 1'b0;
      end
      OP_OV_EV: begin
        if (sts.ov_hit) begin
          if (!found_r) first_r <= i_m1[IDX_W-1:0];
          found_r  <= 1'b1;
          last_r   <= i_r[IDX_W-1:0];
          reason_r <= RSN_OVERLAP;
        end
        if ($signed(srt_q.span_end) > $signed(maxk_r)) maxk_r <= srt_q.span_end;
        i_r <= i_r + CNT_W'(1);
      end
      OP_LV_LDH: begin
        highk_r <= srt_q.span_start;
        lv_r    <= 3'd1;
      end
      OP_LV_RANGE: begin
        r_r <= rng_lv_eff;
        i_r <= '0;
      end
      OP_LV_RD: if (sts.i_last) lv_r <= lv_r + 3'd1;
      OP_LV_LD: begin
        mt_r  <= srt_q.span_start;
        cur_r <= srt_q;
        neg_r <= srt_q.span_start[TIME_W-1];
      end
      OP_LV_DIV: begin
        // A negative start takes the floored remainder, so the gap is r minus it.
        if (div_done) begin
          if (neg_r) gap_r <= (div_rem == '0) ? {1'b0, r_r} : {1'b0, div_rem};
          else       gap_r <= {1'b0, r_r - div_rem};
        end
      end
      OP_LV_FIRST: begin
        if (!sts.exc) begin
          first_r <= i_r[IDX_W-1:0];
          bad_r   <= cur_r.failed_before;
          le_r    <= cur_r.span_end;
        end
        i_r <= i_r + CNT_W'(1);
      end
      OP_LV_GEV: begin
        if (!sts.exc) begin
          bad_r <= bad_r | srt_q.failed_before;
          le_r  <= srt_q.span_end;
          i_r   <= i_r + CNT_W'(1);
        end
      end
      OP_LV_CHK: begin
        last_r   <= i_m1[IDX_W-1:0];
        reason_r <= RSN_LEVELED;
      end
      OP_TB_INIT: begin
        mid_r <= {1'b0, rng_mid_eff} - TIME_W'(1);
        i_r   <= cnt_m1;
      end
      OP_TB_EV: begin
        first_r  <= i_m1[IDX_W-1:0];
        last_r   <= i_m1[IDX_W-1:0];
        reason_r <= RSN_TOMB;
        i_r      <= i_m1;
      end
      OP_EM_INIT: begin
        p_r    <= first_r;
        ecnt_r <= '0;
      end
      OP_EM_OUT: begin
        out_idx_r    <= sidx_ext[PICK_W-1:0];
        out_reason_r <= reason_r;
        out_end_r    <= sts.em_last;
        p_r          <= p_r + IDX_W'(1);
        ecnt_r       <= ecnt_r + PICK_W'(1);
      end
      OP_NONE_OUT: begin
        out_idx_r    <= '0;
        out_reason_r <= RSN_NONE;
        out_end_r    <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_strobe       = out_strobe_r;
  assign out_picked_index = out_idx_r;
  assign out_pick_reason  = out_reason_r;
  assign out_run_end      = out_end_r;

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_RK_WR |-> CNT_W'(rank_r) < cnt_r) else $error("sort rank beyond loaded set");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_EM_OUT |-> p_r <= last_r && first_r <= last_r)
    else $error("emission outside picked range");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_end_r |-> cnt_r == '0) else $error("set not cleared after plan");

endmodule

`default_nettype wire

@@ hw/rtl/lcp_ctrl.sv @@
// Controller of the planner: sequences loading, ranking, the three rules and
// emission, and drives the datapath by command. Uses lcp_pkg.
`default_nettype none

module lcp_ctrl import lcp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     final_block,
  input  lcp_sts_t sts,
  output logic     busy,
  output lcp_cmd_t cmd
);

  lcp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (final_block) state_nxt = S_RK_RDI;
        end
      end
      S_RK_RDI: begin
        cmd.op    = OP_RK_RDI;
        state_nxt = S_RK_LDI;
      end
      S_RK_LDI: begin
        cmd.op    = OP_RK_LDI;
        state_nxt = S_RK_RDJ;
      end
      S_RK_RDJ: begin
        cmd.op    = OP_RK_RDJ;
        state_nxt = S_RK_CMP;
      end
      S_RK_CMP: begin
        cmd.op    = OP_RK_CMP;
        state_nxt = sts.j_end ? S_RK_WR : S_RK_RDJ;
      end
      S_RK_WR: begin
        cmd.op = OP_RK_WR;
        if (!sts.i_last)   state_nxt = S_RK_RDI;
        else if (sts.n_ge2) state_nxt = S_OV_RD0;
        else               state_nxt = S_LV_INIT;
      end
      S_OV_RD0: begin
        cmd.op    = OP_OV_RD0;
        state_nxt = S_OV_LD0;
      end
      S_OV_LD0: begin
        cmd.op    = OP_OV_LD0;
        state_nxt = S_OV_RD;
      end
      S_OV_RD: begin
        cmd.op    = OP_OV_RD;
        state_nxt = S_OV_EV;
      end
      S_OV_EV: begin
        cmd.op = OP_OV_EV;
        // The first overlapping run ends at the first block that does not overlap.
        if (!sts.ov_hit && sts.ov_found) state_nxt = S_EM_INIT;
        else if (sts.i_last) state_nxt = (sts.ov_hit || sts.ov_found) ? S_EM_INIT : S_LV_INIT;
        else state_nxt = S_OV_RD;
      end
      S_LV_INIT: state_nxt = sts.lv_run ? S_LV_RDH : S_TB_INIT;
      S_LV_RDH: begin
        cmd.op    = OP_LV_RDH;
        state_nxt = S_LV_LDH;
      end
      S_LV_LDH: begin
        cmd.op    = OP_LV_LDH;
        state_nxt = S_LV_RANGE;
      end
      S_LV_RANGE: begin
        cmd.op    = OP_LV_RANGE;
        state_nxt = S_LV_RD;
      end
      S_LV_RD: begin
        cmd.op = OP_LV_RD;
        if (sts.i_last) state_nxt = sts.lv_last ? S_TB_INIT : S_LV_RANGE;
        else            state_nxt = S_LV_LD;
      end
      S_LV_LD: begin
        cmd.op    = OP_LV_LD;
        state_nxt = S_LV_DIV;
      end
      S_LV_DIV: begin
        cmd.op = OP_LV_DIV;
        if (sts.div_done) state_nxt = S_LV_FIRST;
      end
      S_LV_FIRST: begin
        cmd.op    = OP_LV_FIRST;
        state_nxt = sts.exc ? S_LV_RD : S_LV_GRD;
      end
      S_LV_GRD: begin
        cmd.op    = OP_LV_GRD;
        state_nxt = sts.i_last ? S_LV_CHK : S_LV_GEV;
      end
      S_LV_GEV: begin
        cmd.op    = OP_LV_GEV;
        state_nxt = sts.exc ? S_LV_CHK : S_LV_GRD;
      end
      S_LV_CHK: begin
        cmd.op    = sts.grp_ok ? OP_LV_CHK : OP_NOP;
        state_nxt = sts.grp_ok ? S_EM_INIT : S_LV_RD;
      end
      S_TB_INIT: begin
        cmd.op    = OP_TB_INIT;
        state_nxt = S_TB_RD;
      end
      S_TB_RD: begin
        cmd.op    = OP_TB_RD;
        state_nxt = sts.k_zero ? S_NONE_OUT : S_TB_EV;
      end
      S_TB_EV: begin
        // The span test reads its operands under this command, so it is always issued.
        cmd.op = OP_TB_EV;
        if (!sts.exc) state_nxt = S_NONE_OUT;
        else          state_nxt = sts.tb_hit ? S_EM_INIT : S_TB_RD;
      end
      S_EM_INIT: begin
        cmd.op    = OP_EM_INIT;
        state_nxt = S_EM_RD;
      end
      S_EM_RD: begin
        cmd.op    = OP_EM_RD;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd.op    = OP_EM_OUT;
        state_nxt = sts.em_last ? S_IDLE : S_EM_RD;
      end
      S_NONE_OUT: begin
        cmd.op    = OP_NONE_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LOAD |-> !busy) else $error("descriptor loaded while planning");

endmodule

`default_nettype wire

@@ hw/rtl/leveled_compaction_planner_core.sv @@
// Top level of the leveled compaction planner: controller plus datapath.
// Depends on lcp_pkg, lcp_ctrl, lcp_dpath and lcp_rem_div.
//
// Usage. A descriptor transaction is taken at a clock edge with start high and
// busy low, one per cycle while busy stays low. Up to MAX_BLOCKS descriptors
// are kept; extra ones are dropped. The descriptor with final_block set starts
// the plan and busy rises on the next cycle.
// Planning runs the ranking, the overlap walk, each range level (every group start
// waits on the remainder unit) and the tombstone walk, in that order.
// Results then leave one at a time, each on the out_ ports for exactly
// one cycle under out_strobe; the last carries out_run_end, or a single none
// result is given. The receiver cannot stall, so nothing waits on it.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them while the block is idle, as the block does not enforce it.
// Reset clears the loaded count and restores the range registers to their
// defaults; the descriptor memories are left undefined.
`default_nettype none

module leveled_compaction_planner_core import lcp_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int MAX_LEVELS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [TIME_W-1:0] in_span_start,
  input  logic signed [TIME_W-1:0] in_span_end,
  input  logic                     in_failed_before,
  input  logic [CNT32_W-1:0]       in_tombstone_count,
  input  logic [CNT32_W-1:0]       in_series_count,
  input  logic                     in_final_block,
  output logic                     out_strobe,
  output logic [PICK_W-1:0]        out_picked_index,
  output logic [1:0]               out_pick_reason,
  output logic                     out_run_end,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [RANGE_W-1:0]       cfg_data
);

  lcp_cmd_t cmd;
  lcp_sts_t sts;

  lcp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .final_block (in_final_block),
    .sts         (sts),
    .busy        (busy),
    .cmd         (cmd)
  );

  lcp_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_span_start      (in_span_start),
    .in_span_end        (in_span_end),
    .in_failed_before   (in_failed_before),
    .in_tombstone_count (in_tombstone_count),
    .in_series_count    (in_series_count),
    .out_strobe         (out_strobe),
    .out_picked_index   (out_picked_index),
    .out_pick_reason    (out_pick_reason),
    .out_run_end        (out_run_end)
  );

endmodule

`default_nettype wire

@@ sim/leveled_compaction_planner_core_tb.sv @@
// Self-checking testbench of the leveled compaction planner core.
// Depends on lcp_pkg and leveled_compaction_planner_core; holds its own plan predictor.
`default_nettype none

module leveled_compaction_planner_core_tb import lcp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 16;

  typedef struct packed {
    logic [PICK_W-1:0] idx;
    lcp_reason_t       rsn;
    logic              last;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [TIME_W-1:0] in_span_start = '0;
  logic signed [TIME_W-1:0] in_span_end = '0;
  logic in_failed_before = 1'b0;
  logic [CNT32_W-1:0] in_tombstone_count = '0;
  logic [CNT32_W-1:0] in_series_count = '0;
  logic in_final_block = 1'b0;
  logic out_strobe;
  logic [PICK_W-1:0] out_picked_index;
  logic [1:0] out_pick_reason;
  logic out_run_end;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RANGE_W-1:0] cfg_data = '0;

  leveled_compaction_planner_core dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  logic [63:0] blk_start [NBLK];
  logic [63:0] blk_end [NBLK];
  logic        blk_failed [NBLK];
  logic [31:0] blk_tomb [NBLK];
  logic [31:0] blk_series [NBLK];
  int          order [NBLK];
  int          stored;
  logic [2:0]  lvl_count;
  logic [62:0] lvl_range [RANGE_REGS];

  pick_t expected_picks[$];
  int    errors = 0;
  int    gap_pct = 0;
  int    range_pct = 13;

  function automatic logic [63:0] okey(logic [63:0] v);
    return v ^ 64'h8000_0000_0000_0000;
  endfunction

  function automatic bit wider_than(logic [63:0] hi, logic [63:0] lo, logic [63:0] gap);
    return okey(hi) > okey(lo) && (hi - lo) > gap;
  endfunction

  function automatic logic [63:0] mod_floor(logic [63:0] t, logic [63:0] r);
    logic [63:0] ra;
    if (!t[63]) return t % r;
    ra = (64'd0 - t) % r;
    return ra == 0 ? 64'd0 : r - ra;
  endfunction

  function automatic logic [63:0] range_of(int lv);
    logic [63:0] r;
    r = {1'b0, lvl_range[lv % 6]};
    return r == 0 ? 64'd1 : r;
  endfunction

  task automatic queue_pick(pick_t p);
    expected_picks = {expected_picks, p};
  endtask

  // Works out the plan over the stored descriptors and queues its picks.
  task automatic predict_plan();
    int n, m, cnt, rc, v, j, lv, i, first, b;
    int picks[NBLK];
    lcp_reason_t rsn;
    logic [63:0] maxk, highk, r, mt, gap, fs, le, mid;
    bit bad, full, done;
    n = stored;
    cnt = 0;
    done = 0;
    rsn = RSN_NONE;
    rc = lvl_count < 1 ? 1 : (lvl_count > 6 ? 6 : lvl_count);
    for (i = 0; i < n; i++) order[i] = i;
    for (i = 1; i < n; i++) begin
      v = order[i];
      j = i;
      while (j > 0 && okey(blk_start[order[j-1]]) > okey(blk_start[v])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    if (n >= 2) begin
      maxk = okey(blk_end[order[0]]);
      for (i = 1; i < n; i++) begin
        b = order[i];
        if (okey(blk_start[b]) < maxk) begin
          if (cnt == 0) picks[cnt++] = order[i-1];
          picks[cnt++] = b;
        end else if (cnt > 0) begin
          break;
        end
        if (okey(blk_end[b]) > maxk) maxk = okey(blk_end[b]);
      end
      if (cnt > 0) begin
        rsn = RSN_OVERLAP;
        done = 1;
      end
    end
    m = n > 0 ? n - 1 : 0;
    if (!done && rc >= 2 && m > 0) begin
      highk = okey(blk_start[order[m-1]]);
      for (lv = 1; lv < rc && !done; lv++) begin
        r = range_of(lv);
        i = 0;
        while (i < m && !done) begin
          mt = blk_start[order[i]];
          gap = r - mod_floor(mt, r);
          if (wider_than(blk_end[order[i]], mt, gap)) begin
            i++;
            continue;
          end
          first = i;
          bad = 0;
          while (i < m && !wider_than(blk_end[order[i]], mt, gap)) begin
            if (blk_failed[order[i]]) bad = 1;
            i++;
          end
          if (!bad && i - first > 1) begin
            fs = blk_start[order[first]];
            le = blk_end[order[i-1]];
            full = okey(le) > okey(fs) && le - fs == r;
            if (full || okey(le) <= highk) begin
              for (j = first; j < i; j++) picks[cnt++] = order[j];
              rsn = RSN_LEVELED;
              done = 1;
            end
          end
        end
      end
    end
    if (!done) begin
      mid = range_of(rc / 2);
      for (j = m; j > 0 && !done; j--) begin
        b = order[j-1];
        if (!wider_than(blk_end[b], blk_start[b], mid - 64'd1)) break;
        if (64'd20 * blk_tomb[b] > {32'd0, blk_series[b]}) begin
          picks[0] = b;
          cnt = 1;
          rsn = RSN_TOMB;
          done = 1;
        end
      end
    end
    stored = 0;
    if (cnt == 0) begin
      queue_pick('{idx: '0, rsn: RSN_NONE, last: 1'b1});
    end else begin
      for (j = 0; j < cnt; j++)
        queue_pick('{idx: picks[j][3:0], rsn: rsn, last: j == cnt - 1});
    end
  endtask

  // Start stays high between back-to-back descriptors and drops only while idling.
  task automatic send_block(logic [63:0] s, logic [63:0] e, logic f, logic [31:0] t,
                            logic [31:0] sc, logic fin);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_span_start <= s;
    in_span_end <= e;
    in_failed_before <= f;
    in_tombstone_count <= t;
    in_series_count <= sc;
    in_final_block <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (stored < NBLK) begin
      blk_start[stored] = s;
      blk_end[stored] = e;
      blk_failed[stored] = f;
      blk_tomb[stored] = t;
      blk_series[stored] = sc;
      stored++;
    end
    if (fin) predict_plan();
    // A final descriptor raises busy next cycle; wait for it before sending more.
    if (fin) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [62:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RANGE_COUNT) lvl_count = val[2:0];
    else if (idx <= REG_RANGE_LAST) lvl_range[idx - 1] = val;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    pick_t exp_p;
    if (rst_n && out_strobe) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result transaction: index %0d", out_picked_index);
        errors++;
      end else begin
        exp_p = expected_picks.pop_front();
        if (out_picked_index !== exp_p.idx) begin
          $error("picked_index expected %0d got %0d", exp_p.idx, out_picked_index);
          errors++;
        end
        if (out_pick_reason !== exp_p.rsn) begin
          $error("pick_reason expected %0d got %0d", exp_p.rsn, out_pick_reason);
          errors++;
        end
        if (out_run_end !== exp_p.last) begin
          $error("run_end expected %0d got %0d", exp_p.last, out_run_end);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    int k;
    // A lone block gives a none result.
    send_block(64'd0, 64'd100, 1'b0, 32'd0, 32'd0, 1'b1);
    // Two overlapping blocks, then extreme timestamps.
    send_block(64'd100, 64'd300, 1'b0, 32'd0, 32'd5, 1'b0);
    send_block(64'd50, 64'd200, 1'b0, 32'd0, 32'd5, 1'b1);
    send_block(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 1'b0);
    send_block(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 32'd0, 32'd0, 1'b1);
    // Leveled group filling an aligned range of level 1.
    send_block(64'd0, 64'd7200000, 1'b0, 32'd0, 32'd1, 1'b0);
    send_block(64'd7200000, 64'd14400000, 1'b0, 32'd0, 32'd1, 1'b0);
    send_block(64'd14400000, 64'd21600000, 1'b0, 32'd0, 32'd1, 1'b0);
    send_block(64'd30000000, 64'd31000000, 1'b0, 32'd0, 32'd1, 1'b1);
    // Wide block with tombstones, zero series case.
    send_block(64'd0, 64'd64800000, 1'b0, 32'd1, 32'd0, 1'b0);
    send_block(64'd70000000, 64'd71000000, 1'b0, 32'd0, 32'd0, 1'b1);
    // Negative times and a failed block in an overlapping pair.
    send_block(-64'sd7200000, -64'sd1, 1'b1, 32'd0, 32'd1, 1'b0);
    send_block(-64'sd100, -64'sd2, 1'b0, 32'd0, 32'd1, 1'b0);
    send_block(64'd5, 64'd6, 1'b0, 32'd0, 32'd1, 1'b1);
    // More than sixteen descriptors: the extras are dropped.
    for (k = 0; k < 18; k++)
      send_block(64'(k * 10), 64'(k * 10 + 20), 1'b0, 32'd0, 32'd0, k == 17);
    drain();
  endtask

  task automatic send_random_set(int nblk, int style);
    logic [63:0] base, s, e, r;
    int k;
    r = range_of(1 + int'($urandom_range(1)));
    base = style == 0 ? {$urandom, $urandom}
                      : r * 64'($urandom_range(20)) - r * 64'd10;
    for (k = 0; k < nblk; k++) begin
      case (style)
        0: begin
          s = {$urandom, $urandom};
          e = {$urandom, $urandom};
        end
        1: begin
          s = base + r / 64'd3 * 64'(k);
          e = s + r / 64'd3;
        end
        default: begin
          s = base + r * 64'(k);
          e = s + r * 64'($urandom_range(3)) - 64'($urandom_range(1));
        end
      endcase
      send_block(s, e, $urandom_range(9) == 0,
                 $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(5)),
                 $urandom_range(2) == 0 ? $urandom : 32'($urandom_range(60)),
                 k == nblk - 1);
    end
  endtask

  task automatic test_random(int items);
    int sent, nblk;
    sent = 0;
    while (sent < items) begin
      nblk = $urandom_range(4) == 0 ? int'($urandom_range(20, 1)) : int'($urandom_range(6, 1));
      send_random_set(nblk, int'($urandom_range(2)));
      sent += nblk;
    end
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(REG_RANGE_COUNT, 63'd6);
    write_reg(3'd1, 63'd1);
    write_reg(3'd2, 63'd1000);
    write_reg(3'd3, 63'd3000);
    write_reg(3'd4, 63'd9000);
    write_reg(3'd5, 63'h7FFF_FFFF_FFFF_FFFF);
    write_reg(REG_RANGE_LAST, 63'd0);
    test_random(40);
    write_reg(REG_RANGE_COUNT, 63'd1);
    test_random(30);
    write_reg(REG_RANGE_COUNT, 63'd0);
    write_reg(3'd7, 63'd5);
    test_random(20);
    write_reg(REG_RANGE_COUNT, 63'd7);
    write_reg(3'd2, 63'h7FFF_FFFF_FFFF_FFFF);
    test_random(20);
    write_reg(REG_RANGE_COUNT, 63'd3);
    write_reg(3'd2, 63'd21600000);
  endtask

  initial begin
    int k;
    stored = 0;
    lvl_count = RANGE_COUNT_RESET;
    for (k = 0; k < RANGE_REGS; k++) lvl_range[k] = RANGE_RESET[k];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    gap_pct = 13;
    test_random(80);
    test_config_sweep();
    gap_pct = 61;
    test_random(70);
    gap_pct = 0;
    test_random(50);
    if (errors == 0 && expected_picks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/lcp_pkg.sv
hw/rtl/lcp_rem_div.sv
hw/rtl/lcp_dpath.sv
hw/rtl/lcp_ctrl.sv
hw/rtl/leveled_compaction_planner_core.sv
sim/leveled_compaction_planner_core_tb.sv
